FILE: src/prime_frequency_lister_top_macros.svh
// ----------------------------------------------------------------------------
// prime_frequency_lister_top_macros.svh
// Assertion macros used by the prime lister controller.
// ----------------------------------------------------------------------------
`ifndef PRIME_FREQUENCY_LISTER_TOP_MACROS_SVH
`define PRIME_FREQUENCY_LISTER_TOP_MACROS_SVH
`ifndef SYNTH
`define PFL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFL_ASSERT(lbl, clk, rst, prop, msg)
`define PFL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/pfl_pkg.sv
// ----------------------------------------------------------------------------
// pfl_pkg
// Shared widths, state codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none
package pfl_pkg;
   localparam int DATA_W        = 32;
   localparam int PRIME_W       = 31;
   localparam int CNT_W         = 7;
   localparam int D_W           = 16;
   localparam int SQ_W          = 2 * D_W;
   localparam int STEP_W        = 5;
   localparam int MAX_ITEMS_DEF = 64;

   typedef enum logic [11:0] {
      ST_LOAD  = 12'b0000_0000_0001,
      ST_TRD   = 12'b0000_0000_0010,
      ST_TLD   = 12'b0000_0000_0100,
      ST_TSQ   = 12'b0000_0000_1000,
      ST_TCMP  = 12'b0000_0001_0000,
      ST_TDIV  = 12'b0000_0010_0000,
      ST_TREM  = 12'b0000_0100_0000,
      ST_TNXT  = 12'b0000_1000_0000,
      ST_SRD   = 12'b0001_0000_0000,
      ST_SCAN  = 12'b0010_0000_0000,
      ST_SDONE = 12'b0100_0000_0000,
      ST_EMIT  = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic load_en;
      logic idx_clr;
      logic idx_inc;
      logic n_load;
      logic sq_calc;
      logic div_start;
      logic d_inc;
      logic flag_wr;
      logic flag_val;
      logic scan_en;
      logic promote;
      logic out_load;
      logic run_clr;
   } cmd_type;

   typedef struct packed {
      logic n_small;
      logic sq_gt;
      logic div_done;
      logic rem_zero;
      logic idx_last;
      logic pend_vld;
      logic cand_vld;
      logic out_last;
   } sts_type;
endpackage
`default_nettype wire

FILE: src/prime_frequency_lister_top.sv
// Operation: items are loaded first; after the final item each stored entry
//   is tested by trial division, each divisor needing a square, a compare
//   and a 31-step pass of the remainder unit.
// Results: each distinct prime needs one scan over the stored entries, reading then comparing each.
// Throughput: one item per cycle while loading; one run at a time.
// Reset: synchronous, active high; clears the item count, overflow and valid bits, and the sequencer.
// ----------------------------------------------------------------------------
// prime_frequency_lister_top
// Lists the distinct primes of a loaded list in ascending order with counts.
// ----------------------------------------------------------------------------
`default_nettype none
module prime_frequency_lister_top #(
   parameter int MAX_ITEMS = pfl_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [pfl_pkg::DATA_W-1:0] req_value,
   input  wire logic                              req_last_item,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [pfl_pkg::PRIME_W-1:0]            rsp_prime,
   output logic [pfl_pkg::CNT_W-1:0]              rsp_occurrences,
   output logic                                   rsp_found,
   output logic                                   rsp_overflowed,
   output logic                                   rsp_last_result
);
   pfl_pkg::cmd_type cmd;
   pfl_pkg::sts_type sts;

   // Sequencer: one item a cycle while loading, then test and scan passes.
   pfl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .sts           (sts)
   );

   // Store, prime flags, remainder unit, scan for the next larger prime,
   // and the result register that holds an item while stalled.
   pfl_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .in_value        (req_value),
      .out_prime       (rsp_prime),
      .out_occurrences (rsp_occurrences),
      .out_found       (rsp_found),
      .out_overflowed  (rsp_overflowed),
      .out_last        (rsp_last_result)
   );
endmodule
`default_nettype wire

FILE: src/pfl_div.sv
// ----------------------------------------------------------------------------
// pfl_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pfl_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pfl_pkg::PRIME_W-1:0] dividend,
   input  wire logic [pfl_pkg::D_W-1:0]     divisor,
   output logic                             done,
   output logic [pfl_pkg::D_W-1:0]          remainder
);
   logic [pfl_pkg::PRIME_W-1:0] shift_ff, shift_in;
   logic [pfl_pkg::D_W-1:0]     rem_ff, rem_in;
   logic [pfl_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [pfl_pkg::D_W:0]       trial;

   always_comb begin
      trial    = {rem_ff, shift_ff[pfl_pkg::PRIME_W-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = pfl_pkg::D_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[pfl_pkg::D_W-1:0];
         end
         step_in = step_ff + 1'b1;
         if (step_ff == pfl_pkg::STEP_W'(pfl_pkg::PRIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

FILE: src/pfl_dp.sv
// ----------------------------------------------------------------------------
// pfl_dp
// Value store, primality test, ascending scan and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module pfl_dp #(
   parameter int MAX_ITEMS = pfl_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pfl_pkg::cmd_type            cmd,
   output pfl_pkg::sts_type                 sts,
   input  wire logic signed [pfl_pkg::DATA_W-1:0] in_value,
   output logic [pfl_pkg::PRIME_W-1:0]      out_prime,
   output logic [pfl_pkg::CNT_W-1:0]        out_occurrences,
   output logic                             out_found,
   output logic                             out_overflowed,
   output logic                             out_last
);
   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   logic [pfl_pkg::DATA_W-1:0]  mem [MAX_ITEMS];
   logic [pfl_pkg::DATA_W-1:0]  rdata_ff;
   logic [MAX_ITEMS-1:0]        flag_ff;
   logic [pfl_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                        drop_ff, drop_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [pfl_pkg::PRIME_W-1:0] n_ff;
   logic [pfl_pkg::D_W-1:0]     d_ff;
   logic [pfl_pkg::SQ_W-1:0]    sq_ff;
   logic [pfl_pkg::PRIME_W-1:0] cand_ff, pend_ff, prev_ff;
   logic [pfl_pkg::CNT_W-1:0]   cand_cnt_ff, pend_cnt_ff;
   logic                        cand_vld_ff, pend_vld_ff, has_prev_ff;
   logic                        can_store;
   logic [pfl_pkg::PRIME_W-1:0] v;
   logic                        v_ok;
   logic                        div_done;
   logic [pfl_pkg::D_W-1:0]     rem;

   assign can_store = count_ff < pfl_pkg::CNT_W'(MAX_ITEMS);
   assign v         = rdata_ff[pfl_pkg::PRIME_W-1:0];
   assign v_ok      = flag_ff[idx_ff] && (!has_prev_ff || v > prev_ff);

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (cmd.run_clr) begin
         count_in = '0;
         drop_in  = 1'b0;
      end else if (cmd.load_en) begin
         if (can_store) count_in = count_ff + 1'b1;
         else           drop_in  = 1'b1;
      end
      idx_in = idx_ff;
      if (cmd.idx_clr)      idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_en && can_store) mem[count_ff[IDX_W-1:0]] <= in_value;
      rdata_ff <= mem[idx_ff];
   end

   // test, scan and result datapath
   always_ff @(posedge clock) begin
      if (cmd.n_load) begin
         n_ff <= rdata_ff[pfl_pkg::PRIME_W-1:0];
         d_ff <= pfl_pkg::D_W'(2);
      end else if (cmd.d_inc) begin
         d_ff <= d_ff + 1'b1;
      end
      if (cmd.sq_calc) sq_ff <= d_ff * d_ff;
      if (cmd.flag_wr) flag_ff[idx_ff] <= cmd.flag_val;
      if (cmd.out_load) begin
         out_prime       <= pend_vld_ff ? pend_ff : '0;
         out_occurrences <= pend_vld_ff ? pend_cnt_ff : '0;
         out_found       <= pend_vld_ff;
         out_overflowed  <= drop_ff;
         out_last        <= !cand_vld_ff;
      end
      if (cmd.promote) begin
         pend_ff     <= cand_ff;
         pend_cnt_ff <= cand_cnt_ff;
         prev_ff     <= cand_ff;
      end
      if (cmd.scan_en && v_ok) begin
         if (!cand_vld_ff || v < cand_ff) begin
            cand_ff     <= v;
            cand_cnt_ff <= pfl_pkg::CNT_W'(1);
         end else if (v == cand_ff) begin
            cand_cnt_ff <= cand_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         drop_ff     <= 1'b0;
         idx_ff      <= '0;
         cand_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         has_prev_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
         idx_ff   <= idx_in;
         if (cmd.run_clr) begin
            cand_vld_ff <= 1'b0;
            pend_vld_ff <= 1'b0;
            has_prev_ff <= 1'b0;
         end else if (cmd.promote) begin
            cand_vld_ff <= 1'b0;
            pend_vld_ff <= 1'b1;
            has_prev_ff <= 1'b1;
         end else if (cmd.scan_en && v_ok) begin
            cand_vld_ff <= 1'b1;
         end
      end
   end

   pfl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .done      (div_done),
      .remainder (rem)
   );

   always_comb begin
      sts.n_small  = $signed(rdata_ff) < $signed(pfl_pkg::DATA_W'(2));
      sts.sq_gt    = sq_ff > {1'b0, n_ff};
      sts.div_done = div_done;
      sts.rem_zero = rem == '0;
      sts.idx_last = pfl_pkg::CNT_W'(idx_ff) + 1'b1 == count_ff;
      sts.pend_vld = pend_vld_ff;
      sts.cand_vld = cand_vld_ff;
      sts.out_last = out_last;
   end
endmodule
`default_nettype wire

FILE: src/pfl_ctrl.sv
// ----------------------------------------------------------------------------
// pfl_ctrl
// Sequencer: load, trial-division test per entry, ascending scans, emit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "prime_frequency_lister_top_macros.svh"
module pfl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last_item,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pfl_pkg::cmd_type      cmd,
   input  wire pfl_pkg::sts_type sts
);
   pfl_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         pfl_pkg::ST_LOAD: begin
            if (req_valid) begin
               cmd.load_en = 1'b1;
               if (req_last_item) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = pfl_pkg::ST_TRD;
               end
            end
         end
         pfl_pkg::ST_TRD: state_in = pfl_pkg::ST_TLD;
         pfl_pkg::ST_TLD: begin
            cmd.n_load = 1'b1;
            if (sts.n_small) begin
               cmd.flag_wr = 1'b1;
               state_in    = pfl_pkg::ST_TNXT;
            end else begin
               state_in = pfl_pkg::ST_TSQ;
            end
         end
         pfl_pkg::ST_TSQ: begin
            cmd.sq_calc = 1'b1;
            state_in    = pfl_pkg::ST_TCMP;
         end
         pfl_pkg::ST_TCMP: begin
            if (sts.sq_gt) begin
               cmd.flag_wr  = 1'b1;
               cmd.flag_val = 1'b1;
               state_in     = pfl_pkg::ST_TNXT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = pfl_pkg::ST_TDIV;
            end
         end
         pfl_pkg::ST_TDIV: begin
            if (sts.div_done) state_in = pfl_pkg::ST_TREM;
         end
         pfl_pkg::ST_TREM: begin
            if (sts.rem_zero) begin
               cmd.flag_wr = 1'b1;
               state_in    = pfl_pkg::ST_TNXT;
            end else begin
               cmd.d_inc = 1'b1;
               state_in  = pfl_pkg::ST_TSQ;
            end
         end
         pfl_pkg::ST_TNXT: begin
            if (sts.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = pfl_pkg::ST_SRD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = pfl_pkg::ST_TRD;
            end
         end
         pfl_pkg::ST_SRD: state_in = pfl_pkg::ST_SCAN;
         pfl_pkg::ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.idx_last) begin
               state_in = pfl_pkg::ST_SDONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = pfl_pkg::ST_SRD;
            end
         end
         pfl_pkg::ST_SDONE: begin
            if (sts.pend_vld || !sts.cand_vld) begin
               cmd.out_load = 1'b1;
               state_in     = pfl_pkg::ST_EMIT;
            end else begin
               cmd.promote = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = pfl_pkg::ST_SRD;
            end
         end
         pfl_pkg::ST_EMIT: begin
            if (!rsp_stall) begin
               if (sts.out_last) begin
                  cmd.run_clr = 1'b1;
                  state_in    = pfl_pkg::ST_LOAD;
               end else begin
                  cmd.promote = 1'b1;
                  cmd.idx_clr = 1'b1;
                  state_in    = pfl_pkg::ST_SRD;
               end
            end
         end
         default: state_in = pfl_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pfl_pkg::ST_LOAD;
      else       state_ff <= state_in;
   end

   assign req_stall = state_ff != pfl_pkg::ST_LOAD;
   assign rsp_valid = state_ff == pfl_pkg::ST_EMIT;

   `PFL_ASSERT(a_cmp_to_div, clock, reset,
      (state_ff == pfl_pkg::ST_TCMP && !sts.sq_gt) |=> state_ff == pfl_pkg::ST_TDIV,
      "divisor below root did not start a division")
   `PFL_ASSERT(a_last_starts, clock, reset,
      (req_valid && !req_stall && req_last_item) |=> state_ff == pfl_pkg::ST_TRD,
      "final item did not start the test pass")
   `PFL_ASSERT(a_final_done, clock, reset,
      (rsp_valid && !rsp_stall && sts.out_last) |=> state_ff == pfl_pkg::ST_LOAD,
      "run did not end after the final item left")
endmodule
`default_nettype wire
